FILE: hdl/att_pkg.sv
// Shared types, constants and reset values of the adaptive tempo tracker.
package att_pkg;

  // Default sizes handed to the top-level parameters
  localparam int HIST_MAX_DEF  = 16;
  localparam int NUM_NOTES_DEF = 128;

  // Datapath widths
  localparam int TIMER_W  = 48;
  localparam int PROD_W   = TIMER_W + 10;  // timer difference times 1000
  localparam int DIV_DW   = 23;            // widest divisor: beat_ms * subdivisions
  localparam int DIV_QW   = 32;
  localparam int DIV_LONG_STEPS  = 32;
  localparam int DIV_SHORT_STEPS = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [31:0] Q16_ONE = 32'h0001_0000;
  localparam logic [15:0] MS_SAT  = 16'hFFFF;

  // Register reset values
  localparam logic        RST_ENABLE      = 1'b0;
  localparam logic        RST_MODE        = 1'b0;
  localparam logic [4:0]  RST_HISTORY_LEN = 5'd4;
  localparam logic [15:0] RST_MIN_MS      = 16'd100;
  localparam logic [15:0] RST_MAX_MS      = 16'd2000;
  localparam logic [17:0] RST_SAMPLE_RATE = 18'd44100;
  localparam logic [15:0] RST_BEAT_MS     = 16'd500;
  localparam logic [6:0]  RST_SUBDIV      = 7'd1;
  localparam logic [15:0] RST_REFILL      = 16'(32'(RST_BEAT_MS) * 32'(RST_SUBDIV));

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_PRESS   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_RESET   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    REG_ENABLE      = 3'd0,
    REG_MODE        = 3'd1,
    REG_HISTORY_LEN = 3'd2,
    REG_MIN_MS      = 3'd3,
    REG_MAX_MS      = 3'd4,
    REG_SAMPLE_RATE = 3'd5,
    REG_BEAT_MS     = 3'd6,
    REG_SUBDIV      = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_MEASURE = 2'd1,
    OP_REFILL  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    F_IDLE = 3'd0,
    F_DIFF = 3'd1,
    F_MUL1 = 3'd2,
    F_MUL2 = 3'd3,
    F_SAT  = 3'd4,
    F_DIV  = 3'd5,
    F_PUSH = 3'd6
  } fstate_e;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_SUM  = 2'd1,
    B_MEAN = 2'd2,
    B_MULT = 2'd3
  } bstate_e;

  typedef struct packed {
    logic        adaptive_enable;
    logic        measure_mode;
    logic [4:0]  history_len;
    logic [15:0] min_ms;
    logic [15:0] max_ms;
    logic [17:0] sample_rate_hz;
    logic [15:0] beat_ms;
    logic [6:0]  subdivisions;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    op_e         op;
    logic [15:0] delta;
  } cmd_t;

  // Request to the iterative divider
  typedef struct packed {
    logic              start;
    logic              long_run;
    logic [DIV_DW-1:0] rem0;
    logic [DIV_QW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

endpackage

FILE: hdl/att_ram.sv
// Generic single-write, single-read RAM with registered read data.
module att_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/att_div.sv
// Restoring divider, one quotient bit per cycle, 16 or 32 steps.
module att_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  att_pkg::div_req_t        req_i,
  output logic                     done_o,
  output logic [att_pkg::DIV_QW-1:0] quo_o
);

  localparam int DW = att_pkg::DIV_DW;
  localparam int QW = att_pkg::DIV_QW;

  logic          busy_q, done_q;
  logic [4:0]    cnt_q;
  logic [DW-1:0] rem_q, den_q;
  logic [QW-1:0] num_q, quo_q;
  logic [DW:0]   trial, trial_sub;
  logic          ge;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial     = {rem_q, num_q[QW-1]};
    trial_sub = trial - {1'b0, den_q};
    ge        = (trial >= {1'b0, den_q});
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.long_run ? 5'(att_pkg::DIV_LONG_STEPS - 1)
                                 : 5'(att_pkg::DIV_SHORT_STEPS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem0;
      den_q <= req_i.den;
      num_q <= req_i.num;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? trial_sub[DW-1:0] : trial[DW-1:0];
      num_q <= {num_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: hdl/att_queue.sv
// Short command queue between the front and back sections.
module att_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  att_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output att_pkg::cmd_t cmd_o,
  output logic          empty_o
);

  localparam int QD  = att_pkg::QUEUE_DEPTH;
  localparam int QAW = (QD > 1) ? $clog2(QD) : 1;

  att_pkg::cmd_t  mem_q [QD];
  logic [QAW-1:0] wp_q, rp_q;
  logic [QAW:0]   cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == (QAW+1)'(QD));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rp_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == QAW'(QD - 1)) ? '0 : wp_q + QAW'(1);
      end
      if (do_pop) begin
        rp_q <= (rp_q == QAW'(QD - 1)) ? '0 : rp_q + QAW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (QAW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (QAW+1)'(1);
      end
    end
  end

  // Store pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

endmodule

FILE: hdl/att_front.sv
// Front section: accepts items, keeps the sample timer, gates notes, computes delta_ms.
module att_front #(
  parameter int NUM_NOTES = att_pkg::NUM_NOTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  att_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    action_i,
  input  logic [12:0]   samples_i,
  input  logic [6:0]    note_i,
  input  logic          from_press_i,
  input  logic          targets_tempo_i,
  output logic          push_o,
  output att_pkg::cmd_t cmd_o,
  input  logic          full_i
);

  localparam int NIW = (NUM_NOTES > 1) ? $clog2(NUM_NOTES) : 1;
  localparam int TW  = att_pkg::TIMER_W;
  localparam int PW  = att_pkg::PROD_W;

  att_pkg::fstate_e  state_q, state_d;
  att_pkg::action_e  action_q;
  att_pkg::op_e      op_q, op_d;
  logic [6:0]        note_q;
  logic              from_press_q, targets_q;
  logic [TW-1:0]     timer_q, last_q, diff_q;
  logic [PW-1:0]     p24_q, n_q;
  logic [15:0]       delta_q;
  logic [NUM_NOTES-1:0] press_vld_q, inv_vld_q;

  logic              press_rd, inv_rd, press_bit, inv_bit;
  logic              in_rng, is_key, gate;
  logic              press_we, inv_we, sat;
  logic              accept;
  logic [NIW-1:0]    nidx;
  att_pkg::div_req_t div_req;
  logic              div_done;
  logic [att_pkg::DIV_QW-1:0] div_quo;

  assign accept = in_valid_i && !in_stall_o;
  assign nidx   = note_q[NIW-1:0];
  assign in_rng = ({1'b0, note_q} < 8'(NUM_NOTES));
  assign is_key = (action_q == att_pkg::ACT_PRESS) || (action_q == att_pkg::ACT_RELEASE);
  assign sat    = (n_q[PW-1:16] >= (PW-16)'(cfg_i.sample_rate_hz));

  // Gate stores: read with the incoming note, written in the cycle after, in F_DIFF
  att_ram #(.WIDTH(1), .DEPTH(NUM_NOTES)) u_press_ram (
    .clk_i   (clk_i),
    .we_i    (press_we),
    .waddr_i (nidx),
    .wdata_i (targets_q),
    .raddr_i (note_i[NIW-1:0]),
    .rdata_o (press_rd)
  );

  att_ram #(.WIDTH(1), .DEPTH(NUM_NOTES)) u_inv_ram (
    .clk_i   (clk_i),
    .we_i    (inv_we),
    .waddr_i (nidx),
    .wdata_i (targets_q),
    .raddr_i (note_i[NIW-1:0]),
    .rdata_o (inv_rd)
  );

  att_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Resolve the note gate and classify the item
  always_comb begin
    press_bit = press_vld_q[nidx] & press_rd;
    inv_bit   = inv_vld_q[nidx] & inv_rd;
    gate      = 1'b0;
    press_we  = 1'b0;
    inv_we    = 1'b0;
    if (is_key && in_rng) begin
      if (from_press_q) begin
        gate = targets_q;
        if (action_q == att_pkg::ACT_PRESS) begin
          press_we = (state_q == att_pkg::F_DIFF);
        end else begin
          inv_we = (state_q == att_pkg::F_DIFF);
        end
      end else begin
        gate = (action_q == att_pkg::ACT_PRESS) ? inv_bit : press_bit;
      end
    end
    op_d = att_pkg::OP_NONE;
    if (action_q == att_pkg::ACT_RESET) begin
      op_d = att_pkg::OP_REFILL;
    end else if (gate && (((action_q == att_pkg::ACT_PRESS) && !cfg_i.measure_mode) ||
                          ((action_q == att_pkg::ACT_RELEASE) && cfg_i.measure_mode))) begin
      op_d = att_pkg::OP_MEASURE;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_d          = state_q;
    in_stall_o       = (state_q != att_pkg::F_IDLE);
    push_o           = 1'b0;
    cmd_o.op         = op_q;
    cmd_o.delta      = delta_q;
    div_req.start    = 1'b0;
    div_req.long_run = 1'b0;
    div_req.rem0     = att_pkg::DIV_DW'(n_q[33:16]);
    div_req.num      = {n_q[15:0], 16'h0000};
    div_req.den      = att_pkg::DIV_DW'(cfg_i.sample_rate_hz);
    case (state_q)
      att_pkg::F_IDLE: begin
        if (in_valid_i) begin
          state_d = att_pkg::F_DIFF;
        end
      end
      att_pkg::F_DIFF: state_d = att_pkg::F_MUL1;
      att_pkg::F_MUL1: state_d = att_pkg::F_MUL2;
      att_pkg::F_MUL2: state_d = att_pkg::F_SAT;
      att_pkg::F_SAT: begin
        if (sat) begin
          state_d = att_pkg::F_PUSH;
        end else begin
          div_req.start = 1'b1;
          state_d       = att_pkg::F_DIV;
        end
      end
      att_pkg::F_DIV: begin
        if (div_done) begin
          state_d = att_pkg::F_PUSH;
        end
      end
      att_pkg::F_PUSH: begin
        push_o = !full_i;
        if (!full_i) begin
          state_d = att_pkg::F_IDLE;
        end
      end
      default: state_d = att_pkg::F_IDLE;
    endcase
  end

  // State, timers and gate valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= att_pkg::F_IDLE;
      timer_q     <= '0;
      last_q      <= '0;
      press_vld_q <= '0;
      inv_vld_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept && (att_pkg::action_e'(action_i) == att_pkg::ACT_TICK)) begin
        timer_q <= timer_q + TW'(samples_i);
      end
      if ((state_q == att_pkg::F_DIFF) && gate && (action_q == att_pkg::ACT_PRESS)) begin
        last_q <= timer_q;
      end
      if (press_we) begin
        press_vld_q[nidx] <= 1'b1;
      end
      if (inv_we) begin
        inv_vld_q[nidx] <= 1'b1;
      end
    end
  end

  // Item fields and delta datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q     <= att_pkg::action_e'(action_i);
      note_q       <= note_i;
      from_press_q <= from_press_i;
      targets_q    <= targets_tempo_i;
    end
    case (state_q)
      att_pkg::F_DIFF: begin
        diff_q <= timer_q - last_q;
        op_q   <= op_d;
      end
      att_pkg::F_MUL1: p24_q <= (PW'(diff_q) << 4) + (PW'(diff_q) << 3);
      att_pkg::F_MUL2: n_q   <= (PW'(diff_q) << 10) - p24_q;
      att_pkg::F_SAT: begin
        if (sat) begin
          delta_q <= att_pkg::MS_SAT;
        end
      end
      att_pkg::F_DIV: begin
        if (div_done) begin
          delta_q <= div_quo[15:0];
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/att_back.sv
// Back section: history window, mean and period multiplier, output register.
module att_back #(
  parameter int HIST_MAX = att_pkg::HIST_MAX_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  att_pkg::cfg_t cfg_i,
  output logic          pop_o,
  input  att_pkg::cmd_t cmd_i,
  input  logic          empty_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [31:0]   period_multiplier_o,
  output logic [15:0]   delta_ms_o,
  output logic          accepted_o
);

  localparam int LENW = $clog2(HIST_MAX + 1);
  localparam int PW   = (HIST_MAX > 1) ? $clog2(HIST_MAX) : 1;
  localparam int CW   = (LENW > 5) ? LENW : 5;
  localparam int SUMW = 16 + LENW;
  localparam int DW   = att_pkg::DIV_DW;

  att_pkg::bstate_e state_q, state_d;
  logic [PW-1:0]    wp_q, rp_q;
  logic [LENW-1:0]  cnt_q, issue_q;
  logic [15:0]      refill_q, delta_q;
  logic [31:0]      mult_q;
  logic [DW-1:0]    bdiv_q;
  logic             pend_q, use_q;
  logic [SUMW-1:0]  acc_q;
  logic             out_valid_q, acc_flag_q;
  logic [31:0]      pm_q;
  logic [15:0]      dms_q;

  logic [CW-1:0]    hl_ext, len_ext;
  logic [LENW-1:0]  len;
  logic             ok, start, load_out, hist_we;
  logic [31:0]      out_pm;
  logic             out_acc;
  logic [15:0]      rd_data;
  att_pkg::div_req_t div_req;
  logic             div_done;
  logic [att_pkg::DIV_QW-1:0] div_quo;

  // Clamp the window length to the history depth
  always_comb begin
    hl_ext  = CW'(cfg_i.history_len);
    len_ext = (hl_ext > CW'(HIST_MAX)) ? CW'(HIST_MAX) : hl_ext;
    len     = len_ext[LENW-1:0];
    ok      = cfg_i.adaptive_enable && (len != '0) &&
              (cmd_i.delta > cfg_i.min_ms) && (cmd_i.delta < cfg_i.max_ms);
  end

  att_ram #(.WIDTH(16), .DEPTH(HIST_MAX)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (wp_q),
    .wdata_i (cmd_i.delta),
    .raddr_i (rp_q),
    .rdata_o (rd_data)
  );

  att_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Next state, pops and divider requests
  always_comb begin
    state_d          = state_q;
    start            = !empty_i && !out_valid_q && (state_q == att_pkg::B_IDLE);
    pop_o            = start;
    hist_we          = 1'b0;
    load_out         = 1'b0;
    out_pm           = mult_q;
    out_acc          = 1'b0;
    div_req.start    = 1'b0;
    div_req.long_run = 1'b0;
    div_req.rem0     = DW'(acc_q[SUMW-1:16]);
    div_req.num      = {acc_q[15:0], 16'h0000};
    div_req.den      = DW'(len);
    case (state_q)
      att_pkg::B_IDLE: begin
        if (start) begin
          case (cmd_i.op)
            att_pkg::OP_REFILL: begin
              load_out = 1'b1;
              out_pm   = att_pkg::Q16_ONE;
            end
            att_pkg::OP_MEASURE: begin
              if (ok) begin
                hist_we = 1'b1;
                state_d = att_pkg::B_SUM;
              end else begin
                load_out = 1'b1;
              end
            end
            default: load_out = 1'b1;
          endcase
        end
      end
      att_pkg::B_SUM: begin
        if ((issue_q == len) && !pend_q) begin
          div_req.start = 1'b1;
          state_d       = att_pkg::B_MEAN;
        end
      end
      att_pkg::B_MEAN: begin
        div_req.long_run = 1'b1;
        div_req.rem0     = '0;
        div_req.num      = {div_quo[15:0], 16'h0000};
        div_req.den      = (bdiv_q == '0) ? DW'(1) : bdiv_q;
        if (div_done) begin
          div_req.start = 1'b1;
          state_d       = att_pkg::B_MULT;
        end
      end
      att_pkg::B_MULT: begin
        if (div_done) begin
          load_out = 1'b1;
          out_pm   = div_quo;
          out_acc  = 1'b1;
          state_d  = att_pkg::B_IDLE;
        end
      end
      default: state_d = att_pkg::B_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= att_pkg::B_IDLE;
      wp_q        <= '0;
      cnt_q       <= '0;
      refill_q    <= att_pkg::RST_REFILL;
      mult_q      <= att_pkg::Q16_ONE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start && (cmd_i.op == att_pkg::OP_REFILL)) begin
        cnt_q    <= '0;
        refill_q <= (|bdiv_q[DW-1:16]) ? att_pkg::MS_SAT : bdiv_q[15:0];
        mult_q   <= att_pkg::Q16_ONE;
      end
      if (hist_we) begin
        wp_q  <= (wp_q == PW'(HIST_MAX - 1)) ? '0 : wp_q + PW'(1);
        cnt_q <= (cnt_q == LENW'(HIST_MAX)) ? cnt_q : cnt_q + LENW'(1);
      end
      if ((state_q == att_pkg::B_MULT) && div_done) begin
        mult_q <= div_quo;
      end
      pend_q <= (state_q == att_pkg::B_SUM) && (issue_q != len);
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Window walk, accumulator and output payload
  always_ff @(posedge clk_i) begin
    bdiv_q <= DW'(cfg_i.beat_ms) * DW'(cfg_i.subdivisions);
    if (hist_we) begin
      rp_q    <= wp_q;
      issue_q <= '0;
      acc_q   <= '0;
      delta_q <= cmd_i.delta;
    end else if (state_q == att_pkg::B_SUM) begin
      if (issue_q != len) begin
        rp_q    <= (rp_q == '0) ? PW'(HIST_MAX - 1) : rp_q - PW'(1);
        issue_q <= issue_q + LENW'(1);
        use_q   <= (issue_q < cnt_q);
      end
      if (pend_q) begin
        acc_q <= acc_q + SUMW'(use_q ? rd_data : refill_q);
      end
    end
    if (load_out) begin
      pm_q       <= out_pm;
      dms_q      <= (state_q == att_pkg::B_MULT) ? delta_q : cmd_i.delta;
      acc_flag_q <= out_acc;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign period_multiplier_o = pm_q;
  assign delta_ms_o          = dms_q;
  assign accepted_o          = acc_flag_q;

endmodule

FILE: hdl/adaptive_tempo_tracker.sv
// Adaptive tempo tracker top level: configuration registers, front, queue and back.
//
// Input channel (in_valid_i / in_stall_o) carries one word per tick, key event or
// history reset. Output channel (out_valid_o / out_stall_i) returns exactly one
// word per input word, in order: period multiplier (Q16.16), delta_ms, accepted.
// Configuration port (cfg_valid_i / cfg_ready_o) is always ready; write it only
// while no word is in flight.
// Front section: fixed steps plus a 16-step divider that turns the sample difference
// into milliseconds; the divider is skipped when the delta saturates. It takes a new
// word only when idle.
// Back section: words that do not touch the history go straight to the output
// register; a word pushed into the history takes a window walk over the history
// RAM, then a 16-step mean division and a 32-step multiplier division.
// A two-word queue lets the front keep accepting while the back works.
// Reset clears the timers, note gates and queue, loads register defaults, refills the
// history with 500 ms and sets the multiplier to 1.0.
// While out_stall_i is high the output word holds; the queue then fills and the
// input stalls.
module adaptive_tempo_tracker #(
  parameter int HIST_MAX  = att_pkg::HIST_MAX_DEF,
  parameter int NUM_NOTES = att_pkg::NUM_NOTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [12:0] samples_i,
  input  logic [6:0]  note_i,
  input  logic        from_press_i,
  input  logic        targets_tempo_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] period_multiplier_o,
  output logic [15:0] delta_ms_o,
  output logic        accepted_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [17:0] cfg_data_i
);

  att_pkg::cfg_t cfg_q;
  att_pkg::cmd_t push_cmd, pop_cmd;
  logic          push, pop, full, empty;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adaptive_enable <= att_pkg::RST_ENABLE;
      cfg_q.measure_mode    <= att_pkg::RST_MODE;
      cfg_q.history_len     <= att_pkg::RST_HISTORY_LEN;
      cfg_q.min_ms          <= att_pkg::RST_MIN_MS;
      cfg_q.max_ms          <= att_pkg::RST_MAX_MS;
      cfg_q.sample_rate_hz  <= att_pkg::RST_SAMPLE_RATE;
      cfg_q.beat_ms         <= att_pkg::RST_BEAT_MS;
      cfg_q.subdivisions    <= att_pkg::RST_SUBDIV;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (att_pkg::reg_e'(cfg_index_i))
        att_pkg::REG_ENABLE:      cfg_q.adaptive_enable <= cfg_data_i[0];
        att_pkg::REG_MODE:        cfg_q.measure_mode    <= cfg_data_i[0];
        att_pkg::REG_HISTORY_LEN: cfg_q.history_len     <= cfg_data_i[4:0];
        att_pkg::REG_MIN_MS:      cfg_q.min_ms          <= cfg_data_i[15:0];
        att_pkg::REG_MAX_MS:      cfg_q.max_ms          <= cfg_data_i[15:0];
        att_pkg::REG_SAMPLE_RATE: cfg_q.sample_rate_hz  <= cfg_data_i;
        att_pkg::REG_BEAT_MS:     cfg_q.beat_ms         <= cfg_data_i[15:0];
        att_pkg::REG_SUBDIV:      cfg_q.subdivisions    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  att_front #(.NUM_NOTES(NUM_NOTES)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .samples_i       (samples_i),
    .note_i          (note_i),
    .from_press_i    (from_press_i),
    .targets_tempo_i (targets_tempo_i),
    .push_o          (push),
    .cmd_o           (push_cmd),
    .full_i          (full)
  );

  att_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (pop_cmd),
    .empty_o (empty)
  );

  att_back #(.HIST_MAX(HIST_MAX)) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .pop_o               (pop),
    .cmd_i               (pop_cmd),
    .empty_i             (empty),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .period_multiplier_o (period_multiplier_o),
    .delta_ms_o          (delta_ms_o),
    .accepted_o          (accepted_o)
  );

endmodule

FILE: hdl/att_checker.sv
// Port-level checker for the adaptive tempo tracker, bound to the top level.
module att_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] period_multiplier_o,
  input logic [15:0] delta_ms_o,
  input logic        accepted_o
);

  // front item, queue entries, back item or output word
  localparam logic [3:0] MAX_PEND = 4'd4;

  logic [3:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Track words in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 4'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(period_multiplier_o) &&
      $stable(delta_ms_o) && $stable(accepted_o))
    else $error("output word changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 4'd0)
    else $error("output word without a pending input word");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= MAX_PEND)
    else $error("more words in flight than the pipeline holds");

  a_accept_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> delta_ms_o != 16'h0000 && delta_ms_o != 16'hFFFF)
    else $error("accepted delta outside the open min/max range");

endmodule

bind adaptive_tempo_tracker att_checker u_att_checker (.*);

FILE: dv/testbench.sv
// Self-checking testbench for the adaptive tempo tracker.
`timescale 1ns / 100ps

module testbench;

  localparam int HALF_PERIOD = 4;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT  = 100;
  localparam int PRINT_CAP   = 100;

  typedef struct packed {
    att_pkg::action_e action;
    logic [12:0]      samples;
    logic [6:0]       note;
    logic             from_press;
    logic             targets;
  } key_word_t;

  typedef struct packed {
    logic [31:0] multiplier;
    logic [15:0] delta_ms;
    logic        accepted;
  } tempo_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = att_pkg::ACT_TICK;
  logic [12:0] samples_i = '0;
  logic [6:0]  note_i = '0;
  logic        from_press_i = 1'b0;
  logic        targets_tempo_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] period_multiplier_o;
  logic [15:0] delta_ms_o;
  logic        accepted_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = att_pkg::REG_ENABLE;
  logic [17:0] cfg_data_i = '0;

  // Stimulus and scoreboard state
  key_word_t     pending_words[$];
  tempo_result_t tempo_due[$];
  int            words_queued = 0;
  int            mismatches = 0;
  int            cycles = 0;
  int            send_gap = 0;
  int            hold_left = 0;
  logic          word_taken = 1'b0;
  logic          quiet = 1'b0;

  // Tracker copy: configuration, timers, history and note gates
  att_pkg::cfg_t tempo_cfg;
  logic [47:0]   sample_clock;
  logic [47:0]   last_onset;
  logic [15:0]   window[16];
  logic [31:0]   multiplier;
  logic [127:0]  press_sel;
  logic [127:0]  invert_sel;

  adaptive_tempo_tracker u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .action_i           (action_i),
    .samples_i          (samples_i),
    .note_i             (note_i),
    .from_press_i       (from_press_i),
    .targets_tempo_i    (targets_tempo_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .period_multiplier_o(period_multiplier_o),
    .delta_ms_o         (delta_ms_o),
    .accepted_o         (accepted_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Refill every history entry with the beat period, saturated to 16 bits
  task automatic refill_window();
    logic [22:0] beat_len;
    beat_len = 23'(tempo_cfg.beat_ms) * 23'(tempo_cfg.subdivisions);
    for (int i = 0; i < 16; i++) begin
      window[i] = (beat_len > 23'hFFFF) ? att_pkg::MS_SAT : beat_len[15:0];
    end
  endtask

  task automatic clear_tracker();
    tempo_cfg = '{att_pkg::RST_ENABLE, att_pkg::RST_MODE, att_pkg::RST_HISTORY_LEN,
                  att_pkg::RST_MIN_MS, att_pkg::RST_MAX_MS, att_pkg::RST_SAMPLE_RATE,
                  att_pkg::RST_BEAT_MS, att_pkg::RST_SUBDIV};
    sample_clock = '0;
    last_onset = '0;
    multiplier = att_pkg::Q16_ONE;
    press_sel = '0;
    invert_sel = '0;
    refill_window();
  endtask

  // Milliseconds since the last counted onset, saturating
  function automatic logic [15:0] elapsed_ms();
    logic [47:0] diff;
    logic [57:0] scaled;
    logic [57:0] ms;
    diff = sample_clock - last_onset;
    if (tempo_cfg.sample_rate_hz == 0) return att_pkg::MS_SAT;
    scaled = 58'(diff) * 58'd1000;
    ms = scaled / 58'(tempo_cfg.sample_rate_hz);
    return (ms > 58'hFFFF) ? att_pkg::MS_SAT : ms[15:0];
  endfunction

  // Push an in-range delta into the window and recompute the multiplier
  function automatic logic push_delta(input logic [15:0] delta);
    logic [4:0]  len;
    logic [20:0] total;
    logic [15:0] mean;
    logic [22:0] divisor;
    logic [31:0] scaled;
    len = (tempo_cfg.history_len > 5'd16) ? 5'd16 : tempo_cfg.history_len;
    if (!tempo_cfg.adaptive_enable || len == 0) return 1'b0;
    if (!(delta > tempo_cfg.min_ms && delta < tempo_cfg.max_ms)) return 1'b0;
    for (int i = 15; i > 0; i--) window[i] = window[i-1];
    window[0] = delta;
    total = '0;
    for (int i = 0; i < len; i++) total = total + 21'(window[i]);
    mean = 16'(total / 21'(len));
    divisor = 23'(tempo_cfg.beat_ms) * 23'(tempo_cfg.subdivisions);
    if (divisor == 0) divisor = 23'd1;
    scaled = {mean, 16'h0000};
    multiplier = scaled / 32'(divisor);
    return 1'b1;
  endfunction

  // Advance the tracker copy by one word and return the result it yields
  task automatic track_tempo(input key_word_t w, output tempo_result_t r);
    logic [15:0] delta;
    logic        gate;
    logic        acc;
    gate = 1'b0;
    acc = 1'b0;
    if (w.action == att_pkg::ACT_TICK) sample_clock = sample_clock + 48'(w.samples);
    delta = elapsed_ms();
    case (w.action)
      att_pkg::ACT_PRESS: begin
        if (w.from_press) begin
          press_sel[w.note] = w.targets;
          gate = w.targets;
        end else begin
          gate = invert_sel[w.note];
        end
        if (gate) begin
          if (tempo_cfg.measure_mode == 1'b0) acc = push_delta(delta);
          last_onset = sample_clock;
        end
      end
      att_pkg::ACT_RELEASE: begin
        if (w.from_press) begin
          invert_sel[w.note] = w.targets;
          gate = w.targets;
        end else begin
          gate = press_sel[w.note];
        end
        if (gate && tempo_cfg.measure_mode == 1'b1) acc = push_delta(delta);
      end
      att_pkg::ACT_RESET: begin
        refill_window();
        multiplier = att_pkg::Q16_ONE;
      end
      default: ;
    endcase
    r = '{multiplier, delta, acc};
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < PRINT_CAP) begin
      $display("%0t mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // Drive input words from the pending queue, with random gaps
  always @(negedge clk_i) begin : drive_words
    key_word_t w;
    if (rst_ni && (!in_valid_i || word_taken)) begin
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_words.size() == 0) begin
        in_valid_i <= 1'b0;
      end else begin
        w = pending_words.pop_front();
        action_i <= w.action;
        samples_i <= w.samples;
        note_i <= w.note;
        from_press_i <= w.from_press;
        targets_tempo_i <= w.targets;
        in_valid_i <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 11);
      end
    end
  end

  // Stall the output side in random bursts
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      out_stall_i <= 1'b1;
      hold_left <= $urandom_range(0, 10);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check results, predict accepted words, track register writes
  always @(posedge clk_i) begin : watch_ports
    key_word_t     w;
    tempo_result_t due;
    tempo_result_t got;
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = '{period_multiplier_o, delta_ms_o, accepted_o};
        if (tempo_due.size() == 0) begin
          flag_mismatch("word with nothing due", 32'(got.delta_ms), 32'h0);
        end else begin
          due = tempo_due.pop_front();
          if (got.multiplier !== due.multiplier)
            flag_mismatch("period_multiplier", got.multiplier, due.multiplier);
          if (got.delta_ms !== due.delta_ms)
            flag_mismatch("delta_ms", 32'(got.delta_ms), 32'(due.delta_ms));
          if (got.accepted !== due.accepted)
            flag_mismatch("accepted", 32'(got.accepted), 32'(due.accepted));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        w = '{att_pkg::action_e'(action_i), samples_i, note_i, from_press_i,
              targets_tempo_i};
        track_tempo(w, due);
        tempo_due.push_back(due);
      end
      word_taken <= in_valid_i && !in_stall_o;
      if (cfg_valid_i && cfg_ready_o) begin
        case (att_pkg::reg_e'(cfg_index_i))
          att_pkg::REG_ENABLE:      tempo_cfg.adaptive_enable = cfg_data_i[0];
          att_pkg::REG_MODE:        tempo_cfg.measure_mode = cfg_data_i[0];
          att_pkg::REG_HISTORY_LEN: tempo_cfg.history_len = cfg_data_i[4:0];
          att_pkg::REG_MIN_MS:      tempo_cfg.min_ms = cfg_data_i[15:0];
          att_pkg::REG_MAX_MS:      tempo_cfg.max_ms = cfg_data_i[15:0];
          att_pkg::REG_SAMPLE_RATE: tempo_cfg.sample_rate_hz = cfg_data_i;
          att_pkg::REG_BEAT_MS:     tempo_cfg.beat_ms = cfg_data_i[15:0];
          att_pkg::REG_SUBDIV:      tempo_cfg.subdivisions = cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input att_pkg::reg_e idx, input logic [17:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_word(input att_pkg::action_e a, input logic [12:0] s,
                            input logic [6:0] n, input logic fp, input logic tt);
    pending_words.push_back('{a, s, n, fp, tt});
    words_queued++;
  endtask

  // Hold until every queued word has gone in and every result has come back
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid_i || tempo_due.size() != 0)
      @(posedge clk_i);
  endtask

  // Queue one phrase: a run of ticks closed by a key event, or a noise word
  task automatic add_phrase(input int tick_max, input int samp_max);
    logic [12:0] s;
    logic [6:0]  nt;
    logic        tt;
    int          kind;
    if ($urandom_range(0, 9) == 0) begin
      queue_word(att_pkg::action_e'($urandom_range(0, 3)), 13'($urandom_range(0, 8191)),
                 7'($urandom_range(0, 127)), 1'($urandom), 1'($urandom));
    end else begin
      repeat ($urandom_range(0, tick_max)) begin
        s = ($urandom_range(0, 15) == 0) ? 13'h1FFF : 13'($urandom_range(0, samp_max));
        queue_word(att_pkg::ACT_TICK, s, 7'($urandom), 1'($urandom), 1'($urandom));
      end
      nt = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, 7)) : 7'($urandom_range(0, 127));
      tt = ($urandom_range(0, 4) != 0);
      kind = $urandom_range(0, 9);
      if (kind < 4)      queue_word(att_pkg::ACT_PRESS, 13'($urandom), nt, 1'b1, tt);
      else if (kind < 7) queue_word(att_pkg::ACT_RELEASE, 13'($urandom), nt, 1'b1, tt);
      else if (kind < 9) queue_word(att_pkg::ACT_PRESS, 13'($urandom), nt, 1'b0, tt);
      else               queue_word(att_pkg::ACT_RELEASE, 13'($urandom), nt, 1'b0, tt);
    end
  endtask

  task automatic run_phrases(input int count, input int tick_max, input int samp_max);
    int target;
    target = words_queued + count;
    while (words_queued < target) add_phrase(tick_max, samp_max);
  endtask

  initial begin
    clear_tracker();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, every action, gate paths in both directions
    write_reg(att_pkg::REG_ENABLE, 18'd1);
    queue_word(att_pkg::ACT_TICK, 13'd0, 7'd0, 1'b0, 1'b0);
    queue_word(att_pkg::ACT_TICK, 13'h1FFF, 7'd0, 1'b0, 1'b0);
    queue_word(att_pkg::ACT_PRESS, 13'd0, 7'd0, 1'b1, 1'b1);
    queue_word(att_pkg::ACT_TICK, 13'h1FFF, 7'd127, 1'b1, 1'b1);
    queue_word(att_pkg::ACT_TICK, 13'h1FFF, 7'd0, 1'b0, 1'b0);
    queue_word(att_pkg::ACT_PRESS, 13'h1FFF, 7'd127, 1'b1, 1'b1);
    queue_word(att_pkg::ACT_RELEASE, 13'd0, 7'd127, 1'b0, 1'b0);
    queue_word(att_pkg::ACT_RELEASE, 13'd0, 7'd5, 1'b1, 1'b1);
    queue_word(att_pkg::ACT_TICK, 13'd4096, 7'd0, 1'b0, 1'b0);
    queue_word(att_pkg::ACT_PRESS, 13'd0, 7'd5, 1'b0, 1'b0);
    queue_word(att_pkg::ACT_PRESS, 13'd0, 7'd9, 1'b1, 1'b0);
    queue_word(att_pkg::ACT_TICK, 13'h1FFF, 7'd0, 1'b0, 1'b0);
    queue_word(att_pkg::ACT_PRESS, 13'd0, 7'd9, 1'b0, 1'b1);
    queue_word(att_pkg::ACT_RELEASE, 13'd0, 7'd9, 1'b0, 1'b1);
    queue_word(att_pkg::ACT_PRESS, 13'd0, 7'd3, 1'b1, 1'b1);
    queue_word(att_pkg::ACT_TICK, 13'd5000, 7'd0, 1'b0, 1'b0);
    queue_word(att_pkg::ACT_RELEASE, 13'd0, 7'd3, 1'b1, 1'b1);
    queue_word(att_pkg::ACT_RESET, 13'h1FFF, 7'd127, 1'b1, 1'b1);
    queue_word(att_pkg::ACT_TICK, 13'd4096, 7'd0, 1'b0, 1'b0);
    queue_word(att_pkg::ACT_PRESS, 13'd0, 7'd0, 1'b1, 1'b1);
    wait_drained();

    // Default window; the sender pauses mid-way until every result is back
    run_phrases(175, 12, 8191);
    wait_drained();
    run_phrases(175, 12, 8191);
    wait_drained();

    // Note length, full window, lowest rate, open limits, unit beat
    write_reg(att_pkg::REG_MODE, 18'd1);
    write_reg(att_pkg::REG_HISTORY_LEN, 18'd16);
    write_reg(att_pkg::REG_MIN_MS, 18'd0);
    write_reg(att_pkg::REG_MAX_MS, 18'd65535);
    write_reg(att_pkg::REG_SAMPLE_RATE, 18'd8000);
    write_reg(att_pkg::REG_BEAT_MS, 18'd1);
    write_reg(att_pkg::REG_SUBDIV, 18'd1);
    run_phrases(350, 12, 2000);
    wait_drained();

    // Window length saturates, refill saturates, highest nominal rate
    write_reg(att_pkg::REG_MODE, 18'd0);
    write_reg(att_pkg::REG_HISTORY_LEN, 18'd31);
    write_reg(att_pkg::REG_MIN_MS, 18'd50);
    write_reg(att_pkg::REG_MAX_MS, 18'd1000);
    write_reg(att_pkg::REG_SAMPLE_RATE, 18'd192000);
    write_reg(att_pkg::REG_BEAT_MS, 18'd65535);
    write_reg(att_pkg::REG_SUBDIV, 18'd127);
    run_phrases(350, 20, 8191);
    wait_drained();

    // Zero window, zero rate, zero divisor, inverted limits
    write_reg(att_pkg::REG_MODE, 18'd1);
    write_reg(att_pkg::REG_HISTORY_LEN, 18'd0);
    write_reg(att_pkg::REG_SAMPLE_RATE, 18'd0);
    write_reg(att_pkg::REG_BEAT_MS, 18'd0);
    write_reg(att_pkg::REG_SUBDIV, 18'd0);
    write_reg(att_pkg::REG_MIN_MS, 18'd65535);
    write_reg(att_pkg::REG_MAX_MS, 18'd0);
    run_phrases(200, 6, 8191);
    wait_drained();

    // Tracker disabled, single-entry window
    write_reg(att_pkg::REG_ENABLE, 18'd0);
    write_reg(att_pkg::REG_MODE, 18'd0);
    write_reg(att_pkg::REG_HISTORY_LEN, 18'd1);
    write_reg(att_pkg::REG_SAMPLE_RATE, 18'd48000);
    write_reg(att_pkg::REG_MIN_MS, 18'd20);
    write_reg(att_pkg::REG_MAX_MS, 18'd3000);
    write_reg(att_pkg::REG_BEAT_MS, 18'd250);
    write_reg(att_pkg::REG_SUBDIV, 18'd4);
    run_phrases(250, 10, 8191);
    wait_drained();

    // Window grown over held entries, widest rate, zero beat; no idling
    quiet = 1'b1;
    write_reg(att_pkg::REG_ENABLE, 18'd1);
    write_reg(att_pkg::REG_MODE, 18'd1);
    write_reg(att_pkg::REG_HISTORY_LEN, 18'd8);
    write_reg(att_pkg::REG_SAMPLE_RATE, 18'h3FFFF);
    write_reg(att_pkg::REG_MIN_MS, 18'd1);
    write_reg(att_pkg::REG_MAX_MS, 18'd400);
    write_reg(att_pkg::REG_BEAT_MS, 18'd0);
    write_reg(att_pkg::REG_SUBDIV, 18'd64);
    run_phrases(400, 12, 8191);
    wait_drained();

    // Let any stray word show up before the verdict
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && tempo_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/att_pkg.sv
hdl/att_ram.sv
hdl/att_div.sv
hdl/att_queue.sv
hdl/att_front.sv
hdl/att_back.sv
hdl/adaptive_tempo_tracker.sv
hdl/att_checker.sv
dv/testbench.sv
